@@ hdl/gtg_pkg.sv @@
// Shared types, constants and arctangent table for the go-to-goal controller.
`timescale 1ns / 1ps

package gtg_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int MAX_STEPS    = 20;
    localparam int VW           = 36;   // vector word, 12 fraction bits
    localparam int ZW           = 28;   // angle word, 24 fraction bits

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    localparam ang_t ANG_PI      = ZW'(52707179);
    localparam ang_t ANG_HALF_PI = ZW'(26353590);
    localparam logic [29:0] GAIN_INV = 30'd652032874;

    localparam ang_t ATAN_TABLE [MAX_STEPS] = '{
        ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331), ZW'(1047214),
        ZW'(524117),   ZW'(262123),  ZW'(131069),  ZW'(65536),   ZW'(32768),
        ZW'(16384),    ZW'(8192),    ZW'(4096),    ZW'(2048),    ZW'(1024),
        ZW'(512),      ZW'(256),     ZW'(128),     ZW'(64),      ZW'(32)
    };

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    typedef enum logic [2:0] {
        REG_LINEAR_GAIN   = 3'd0,
        REG_ANGULAR_GAIN  = 3'd1,
        REG_DIST_TOL      = 3'd2,
        REG_HEADING_TOL   = 3'd3,
        REG_DIST_LIMIT    = 3'd4
    } cfg_reg_t;

    // Pose fields carried alongside the CORDIC datapath
    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] robot_x;
        logic signed [15:0] robot_y;
        logic signed [14:0] robot_heading;
        logic signed [15:0] leader_x;
        logic signed [15:0] leader_y;
        logic signed [14:0] leader_heading;
        logic               goal_is_relative;
    } side_t;

endpackage

@@ hdl/go_to_goal_p_controller_unit.sv @@
// Top level of the go-to-goal proportional controller pipeline.
`timescale 1ns / 1ps

// One pose beat in, one command beat out, one beat per cycle sustained. The depth is set
// by three chained CORDIC pipelines: goal rotation into the world frame, error rotation
// into the body frame, and vectoring for distance and bearing. The whole pipeline holds
// while the output beat waits, so nothing is lost or repeated. Write configuration only
// while idle; cfg_ready is always high and indexes 5 to 7 are ignored.
module go_to_goal_p_controller_unit
    import gtg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // goal_x[15:0] goal_y[31:16] robot_x[47:32] robot_y[63:48] robot_heading[78:64]
    // leader_x[94:79] leader_y[110:95] leader_heading[125:111], zero pad
    input  logic [127:0]  s_axis_tdata,
    // goal_is_relative
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // linear_speed[14:0] angular_rate[30:15], zero pad
    output logic [31:0]   m_axis_tdata,
    // at_goal
    output logic          m_axis_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    logic [15:0] lin_gain_reg;
    logic [15:0] ang_gain_reg;
    logic [14:0] dist_tol_reg;
    logic [14:0] head_tol_reg;
    logic [14:0] dist_lim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg <= 16'd4096;
            ang_gain_reg <= 16'd7373;
            dist_tol_reg <= 15'd102;
            head_tol_reg <= 15'd41;
            dist_lim_reg <= 15'd2048;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINEAR_GAIN:  lin_gain_reg <= cfg_data;
                REG_ANGULAR_GAIN: ang_gain_reg <= cfg_data;
                REG_DIST_TOL:     dist_tol_reg <= cfg_data[14:0];
                REG_HEADING_TOL:  head_tol_reg <= cfg_data[14:0];
                REG_DIST_LIMIT:   dist_lim_reg <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    logic en;
    logic o_valid_reg;

    assign en            = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Input register
    logic  i_valid_reg;
    side_t i_side_reg;
    side_t i_side_next;

    always_comb
    begin
        i_side_next.goal_x           = s_axis_tdata[15:0];
        i_side_next.goal_y           = s_axis_tdata[31:16];
        i_side_next.robot_x          = s_axis_tdata[47:32];
        i_side_next.robot_y          = s_axis_tdata[63:48];
        i_side_next.robot_heading    = s_axis_tdata[78:64];
        i_side_next.leader_x         = s_axis_tdata[94:79];
        i_side_next.leader_y         = s_axis_tdata[110:95];
        i_side_next.leader_heading   = s_axis_tdata[125:111];
        i_side_next.goal_is_relative = s_axis_tuser;
    end

    // Fold A: rotate goal by leader heading
    vec_t fa_x;
    vec_t fa_y;
    ang_t fa_z;
    ang_t za;

    always_comb
    begin
        za   = ang_t'(i_side_reg.leader_heading) <<< 12;
        fa_x = vec_t'(i_side_reg.goal_x) <<< 12;
        fa_y = vec_t'(i_side_reg.goal_y) <<< 12;
        fa_z = za;
        if (za > ANG_HALF_PI)
        begin
            fa_x = -fa_x;
            fa_y = -fa_y;
            fa_z = za - ANG_PI;
        end
        else if (za < -ANG_HALF_PI)
        begin
            fa_x = -fa_x;
            fa_y = -fa_y;
            fa_z = za + ANG_PI;
        end
    end

    logic  a_valid;
    vec_t  a_x;
    vec_t  a_y;
    ang_t  a_z;
    side_t a_side;

    gtg_cordic u_cordic_goal (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (CORDIC_ROTATE),
        .in_valid  (i_valid_reg),
        .in_x      (fa_x),
        .in_y      (fa_y),
        .in_z      (fa_z),
        .in_side   (i_side_reg),
        .out_valid (a_valid),
        .out_x     (a_x),
        .out_y     (a_y),
        .out_z     (a_z),
        .out_side  (a_side)
    );

    // World-frame error
    logic  e_valid_reg;
    vec_t  ex_reg;
    vec_t  ey_reg;
    side_t e_side_reg;
    vec_t  gx_w;
    vec_t  gy_w;

    always_comb
    begin
        if (a_side.goal_is_relative)
        begin
            gx_w = a_x + (vec_t'(a_side.leader_x) <<< 12);
            gy_w = a_y + (vec_t'(a_side.leader_y) <<< 12);
        end
        else
        begin
            gx_w = vec_t'(a_side.goal_x) <<< 12;
            gy_w = vec_t'(a_side.goal_y) <<< 12;
        end
    end

    // Fold B: rotate error by minus robot heading
    vec_t fb_x;
    vec_t fb_y;
    ang_t fb_z;
    ang_t zb;

    always_comb
    begin
        zb   = -(ang_t'(e_side_reg.robot_heading) <<< 12);
        fb_x = ex_reg;
        fb_y = ey_reg;
        fb_z = zb;
        if (zb > ANG_HALF_PI)
        begin
            fb_x = -ex_reg;
            fb_y = -ey_reg;
            fb_z = zb - ANG_PI;
        end
        else if (zb < -ANG_HALF_PI)
        begin
            fb_x = -ex_reg;
            fb_y = -ey_reg;
            fb_z = zb + ANG_PI;
        end
    end

    logic  b_valid;
    vec_t  b_x;
    vec_t  b_y;
    ang_t  b_z;
    side_t b_side;

    gtg_cordic u_cordic_body (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (CORDIC_ROTATE),
        .in_valid  (e_valid_reg),
        .in_x      (fb_x),
        .in_y      (fb_y),
        .in_z      (fb_z),
        .in_side   (e_side_reg),
        .out_valid (b_valid),
        .out_x     (b_x),
        .out_y     (b_y),
        .out_z     (b_z),
        .out_side  (b_side)
    );

    // Fold C: move vector into the right half plane before vectoring
    vec_t fc_x;
    vec_t fc_y;
    ang_t fc_z;

    always_comb
    begin
        fc_x = b_x;
        fc_y = b_y;
        fc_z = '0;
        if (b_x[VW-1])
        begin
            fc_x = -b_x;
            fc_y = -b_y;
            fc_z = b_y[VW-1] ? -ANG_PI : ANG_PI;
        end
    end

    logic  c_valid;
    vec_t  c_len;
    vec_t  c_y;
    ang_t  c_z;
    side_t c_side;

    gtg_cordic u_cordic_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (CORDIC_VECTOR),
        .in_valid  (b_valid),
        .in_x      (fc_x),
        .in_y      (fc_y),
        .in_z      (fc_z),
        .in_side   (b_side),
        .out_valid (c_valid),
        .out_x     (c_len),
        .out_y     (c_y),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    // Round and clamp distance, round bearing
    logic               t2_valid_reg;
    logic        [14:0] d_reg;
    logic signed [15:0] bear_reg;
    logic signed [15:0] herr_reg;
    vec_t               len_r;
    vec_t               d_raw;
    ang_t               z_r;
    logic        [14:0] d_next;

    always_comb
    begin
        len_r = c_len + vec_t'(2048);
        d_raw = len_r >>> 12;
        z_r   = c_z + ang_t'(2048);
        if (d_raw[VW-1])
        begin
            d_next = '0;
        end
        else if (d_raw > $signed({{(VW-15){1'b0}}, dist_lim_reg}))
        begin
            d_next = dist_lim_reg;
        end
        else
        begin
            d_next = d_raw[14:0];
        end
    end

    // Goal test and heading error select
    logic               t3_valid_reg;
    logic               at_goal_reg;
    logic        [14:0] sd_reg;
    logic signed [15:0] err_reg;
    logic               at_goal_next;
    logic signed [16:0] herr17;
    logic signed [16:0] tol17;
    logic signed [15:0] err_next;

    always_comb
    begin
        at_goal_next = d_reg < dist_tol_reg;
        herr17       = 17'(herr_reg);
        tol17        = $signed({2'b00, head_tol_reg});
        if (!at_goal_next)
        begin
            err_next = bear_reg;
        end
        else if (herr17 < tol17 && herr17 > -tol17)
        begin
            err_next = '0;
        end
        else
        begin
            err_next = herr_reg;
        end
    end

    // Gain products
    logic               t4_valid_reg;
    logic               t4_goal_reg;
    logic        [30:0] sp_reg;
    logic signed [32:0] rt_reg;

    // Output rounding and saturation
    logic        [31:0] sp_r;
    logic signed [33:0] rt_r;
    logic        [14:0] speed_next;
    logic signed [15:0] rate_next;
    logic        [14:0] speed_reg;
    logic signed [15:0] rate_reg;
    logic               goal_out_reg;

    always_comb
    begin
        sp_r = {1'b0, sp_reg} + 32'd2048;
        rt_r = 34'(rt_reg) + 34'sd2048;
        if (sp_r[31:12] > 20'd32767)
        begin
            speed_next = 15'h7FFF;
        end
        else
        begin
            speed_next = sp_r[26:12];
        end
        if ((rt_r >>> 12) > 34'sd32767)
        begin
            rate_next = 16'sh7FFF;
        end
        else if ((rt_r >>> 12) < -34'sd32768)
        begin
            rate_next = -16'sh8000;
        end
        else
        begin
            rate_next = rt_r[27:12];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            i_valid_reg  <= s_axis_tvalid;
            e_valid_reg  <= a_valid;
            t2_valid_reg <= c_valid;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            o_valid_reg  <= t4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_side_reg   <= i_side_next;
            ex_reg       <= gx_w - (vec_t'(a_side.robot_x) <<< 12);
            ey_reg       <= gy_w - (vec_t'(a_side.robot_y) <<< 12);
            e_side_reg   <= a_side;
            d_reg        <= d_next;
            bear_reg     <= z_r[ZW-1:12];
            herr_reg     <= 16'(c_side.leader_heading) - 16'(c_side.robot_heading);
            at_goal_reg  <= at_goal_next;
            sd_reg       <= at_goal_next ? 15'd0 : d_reg;
            err_reg      <= err_next;
            t4_goal_reg  <= at_goal_reg;
            sp_reg       <= {15'd0, lin_gain_reg} * {16'd0, sd_reg};
            rt_reg       <= $signed({17'd0, ang_gain_reg}) * 33'(err_reg);
            speed_reg    <= speed_next;
            rate_reg     <= rate_next;
            goal_out_reg <= t4_goal_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {1'b0, rate_reg, speed_reg};
    assign m_axis_tuser  = goal_out_reg;

endmodule

@@ hdl/gtg_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per stage, followed by gain compensation.
`timescale 1ns / 1ps

module gtg_cordic
    import gtg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  cordic_mode_t mode,
    input  logic         in_valid,
    input  vec_t         in_x,
    input  vec_t         in_y,
    input  ang_t         in_z,
    input  side_t        in_side,
    output logic         out_valid,
    output vec_t         out_x,
    output vec_t         out_y,
    output ang_t         out_z,
    output side_t        out_side
);

    logic [CORDIC_STEPS-1:0] v_reg;
    vec_t  x_reg [CORDIC_STEPS];
    vec_t  y_reg [CORDIC_STEPS];
    ang_t  z_reg [CORDIC_STEPS];
    side_t s_reg [CORDIC_STEPS];

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_step
            logic  vi;
            vec_t  xi;
            vec_t  yi;
            ang_t  zi;
            side_t si;
            logic  cw;
            vec_t  x_next;
            vec_t  y_next;
            ang_t  z_next;

            if (k == 0)
            begin : g_first
                assign vi = in_valid;
                assign xi = in_x;
                assign yi = in_y;
                assign zi = in_z;
                assign si = in_side;
            end
            else
            begin : g_rest
                assign vi = v_reg[k-1];
                assign xi = x_reg[k-1];
                assign yi = y_reg[k-1];
                assign zi = z_reg[k-1];
                assign si = s_reg[k-1];
            end

            always_comb
            begin
                cw = (mode == CORDIC_ROTATE) ? !zi[ZW-1] : yi[VW-1];
                if (cw)
                begin
                    x_next = xi - (yi >>> k);
                    y_next = yi + (xi >>> k);
                    z_next = zi - ATAN_TABLE[k];
                end
                else
                begin
                    x_next = xi + (yi >>> k);
                    y_next = yi - (xi >>> k);
                    z_next = zi + ATAN_TABLE[k];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k] <= x_next;
                    y_reg[k] <= y_next;
                    z_reg[k] <= z_next;
                    s_reg[k] <= si;
                end
            end
        end
    endgenerate

    // Gain compensation: split the word so each multiply stays narrow
    logic               c1_valid_reg;
    logic        [47:0] xl_reg;
    logic signed [47:0] xh_reg;
    logic        [47:0] yl_reg;
    logic signed [47:0] yh_reg;
    ang_t               c1_z_reg;
    side_t              c1_s_reg;

    logic        [47:0] xl_next;
    logic signed [47:0] xh_next;
    logic        [47:0] yl_next;
    logic signed [47:0] yh_next;
    vec_t               xs;
    vec_t               ys;

    assign xs = x_reg[CORDIC_STEPS-1];
    assign ys = y_reg[CORDIC_STEPS-1];

    always_comb
    begin
        xl_next = {30'd0, xs[17:0]} * {18'd0, GAIN_INV};
        yl_next = {30'd0, ys[17:0]} * {18'd0, GAIN_INV};
        xh_next = $signed({{30{xs[VW-1]}}, xs[VW-1:18]}) * $signed({18'd0, GAIN_INV});
        yh_next = $signed({{30{ys[VW-1]}}, ys[VW-1:18]}) * $signed({18'd0, GAIN_INV});
    end

    logic  c2_valid_reg;
    vec_t  c2_x_reg;
    vec_t  c2_y_reg;
    ang_t  c2_z_reg;
    side_t c2_s_reg;

    logic signed [67:0] xsum;
    logic signed [67:0] ysum;

    always_comb
    begin
        xsum = $signed({{2{xh_reg[47]}}, xh_reg, 18'd0}) + $signed({20'd0, xl_reg})
             + 68'sd536870912;
        ysum = $signed({{2{yh_reg[47]}}, yh_reg, 18'd0}) + $signed({20'd0, yl_reg})
             + 68'sd536870912;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= v_reg[CORDIC_STEPS-1];
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xl_reg   <= xl_next;
            xh_reg   <= xh_next;
            yl_reg   <= yl_next;
            yh_reg   <= yh_next;
            c1_z_reg <= z_reg[CORDIC_STEPS-1];
            c1_s_reg <= s_reg[CORDIC_STEPS-1];
            c2_x_reg <= xsum[VW+29:30];
            c2_y_reg <= ysum[VW+29:30];
            c2_z_reg <= c1_z_reg;
            c2_s_reg <= c1_s_reg;
        end
    end

    assign out_valid = c2_valid_reg;
    assign out_x     = c2_x_reg;
    assign out_y     = c2_y_reg;
    assign out_z     = c2_z_reg;
    assign out_side  = c2_s_reg;

endmodule

@@ tb/sv/go_to_goal_p_controller_unit_test.sv @@
// Self-checking testbench for the go-to-goal controller: directed table, then random poses.
`timescale 1ns / 1ps

module go_to_goal_p_controller_unit_test
    import gtg_pkg::*;
();

    typedef struct packed {
        logic [14:0]        speed;
        logic signed [15:0] rate;
        logic               at_goal;
    } command_t;

    typedef struct {
        side_t    pose;
        bit       known;
        command_t cmd;
    } pose_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    longint   lin_gain, ang_gain, dist_tol, head_tol, dist_lim;
    command_t pending_cmds[$];
    command_t typed_cmds[$];
    bit       typed_flags[$];
    int       errors = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;

    always #5 clk = ~clk;

    go_to_goal_p_controller_unit dut (.*);

    function automatic longint apply_gain_comp(longint v);
        return (v * longint'(GAIN_INV) + (longint'(1) <<< 29)) >>> 30;
    endfunction

    function automatic void rotate_vec(inout longint x, inout longint y, input longint a);
        longint z, vx, vy, dx, dy;
        z = a * 4096;
        vx = x;
        vy = y;
        if (z > longint'(ANG_HALF_PI))
        begin
            vx = -vx; vy = -vy; z -= longint'(ANG_PI);
        end
        else if (z < -longint'(ANG_HALF_PI))
        begin
            vx = -vx; vy = -vy; z += longint'(ANG_PI);
        end
        for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (z >= 0)
            begin
                vx -= dx; vy += dy; z -= longint'(ATAN_TABLE[i]);
            end
            else
            begin
                vx += dx; vy -= dy; z += longint'(ATAN_TABLE[i]);
            end
        end
        x = apply_gain_comp(vx);
        y = apply_gain_comp(vy);
    endfunction

    // Returns bearing with 24 fraction bits; length goes out through len.
    function automatic longint bearing_of(longint x, longint y, output longint len);
        longint z, dx, dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < MAX_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TABLE[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(ATAN_TABLE[i]);
            end
        end
        len = apply_gain_comp(x);
        return z;
    endfunction

    function automatic command_t steer_command(side_t p);
        command_t c;
        longint gx, gy, ex, ey, len, z, d, err, speed, rate, rh, lh;
        gx = longint'(p.goal_x) * 4096;
        gy = longint'(p.goal_y) * 4096;
        rh = longint'(p.robot_heading);
        lh = longint'(p.leader_heading);
        if (p.goal_is_relative)
        begin
            rotate_vec(gx, gy, lh);
            gx += longint'(p.leader_x) * 4096;
            gy += longint'(p.leader_y) * 4096;
        end
        ex = gx - longint'(p.robot_x) * 4096;
        ey = gy - longint'(p.robot_y) * 4096;
        rotate_vec(ex, ey, -rh);
        z = bearing_of(ex, ey, len);
        d = (len + 2048) >>> 12;
        if (d < 0)
            d = 0;
        if (d > dist_lim)
            d = dist_lim;
        c.at_goal = d < dist_tol;
        if (c.at_goal)
        begin
            speed = 0;
            err = lh - rh;
            if (err < head_tol && err > -head_tol)
                err = 0;
        end
        else
        begin
            speed = (lin_gain * d + 2048) >>> 12;
            if (speed > 32767)
                speed = 32767;
            err = (z + 2048) >>> 12;
        end
        rate = (ang_gain * err + 2048) >>> 12;
        if (rate > 32767)
            rate = 32767;
        if (rate < -32768)
            rate = -32768;
        c.speed = speed[14:0];
        c.rate = rate[15:0];
        return c;
    endfunction

    function automatic pose_row_t row(int gx, int gy, int rx, int ry, int rh,
                                      int lx, int ly, int lh, bit rel,
                                      bit known = 0, int sp = 0, int rt = 0, bit ag = 0);
        pose_row_t r;
        r.pose = '{goal_x: 16'(gx), goal_y: 16'(gy), robot_x: 16'(rx), robot_y: 16'(ry),
                   robot_heading: 15'(rh), leader_x: 16'(lx), leader_y: 16'(ly),
                   leader_heading: 15'(lh), goal_is_relative: rel};
        r.known = known;
        r.cmd = '{speed: 15'(sp), rate: 16'(rt), at_goal: ag};
        return r;
    endfunction

    function automatic side_t random_pose();
        side_t p;
        int    kind, span;
        p = side_t'(127'({$urandom, $urandom, $urandom, $urandom}));
        kind = $urandom_range(9);
        p.robot_heading = 15'($urandom_range(25736) - 12868);
        p.leader_heading = 15'($urandom_range(25736) - 12868);
        if (kind >= 2)
        begin
            // close or moderate offset from the robot, so both branches are hit
            span = (kind < 6) ? 150 : 3000;
            p.goal_x = p.robot_x + 16'($urandom_range(2 * span) - span);
            p.goal_y = p.robot_y + 16'($urandom_range(2 * span) - span);
            p.goal_is_relative = ($urandom_range(3) == 0);
            if (p.goal_is_relative)
            begin
                p.leader_x = p.robot_x + 16'($urandom_range(2 * span) - span);
                p.leader_y = p.robot_y + 16'($urandom_range(2 * span) - span);
                p.goal_x = 16'($urandom_range(2 * span) - span);
                p.goal_y = 16'($urandom_range(2 * span) - span);
            end
        end
        return p;
    endfunction

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LINEAR_GAIN:  lin_gain = value & 16'hFFFF;
            REG_ANGULAR_GAIN: ang_gain = value & 16'hFFFF;
            REG_DIST_TOL:     dist_tol = value & 15'h7FFF;
            REG_HEADING_TOL:  head_tol = value & 15'h7FFF;
            REG_DIST_LIMIT:   dist_lim = value & 15'h7FFF;
            default: ;
        endcase
    endtask

    task automatic send_pose(side_t p, bit known, command_t cmd);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= p.goal_is_relative;
        s_axis_tdata <= {2'b00, p.leader_heading, p.leader_y, p.leader_x, p.robot_heading,
                         p.robot_y, p.robot_x, p.goal_y, p.goal_x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_cmds.push_back(steer_command(p));
        typed_cmds.push_back(cmd);
        typed_flags.push_back(known);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic run_random(int count);
        command_t none;
        none = '{speed: '0, rate: '0, at_goal: 1'b0};
        for (int n = 0; n < count; n++)
            send_pose(random_pose(), 1'b0, none);
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        command_t exp_cmd, typed;
        bit       known;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h", $realtime, m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_cmd = pending_cmds.pop_front();
                typed = typed_cmds.pop_front();
                known = typed_flags.pop_front();
                // typed rows must also agree with the predictor
                if (known && typed != exp_cmd)
                begin
                    $display("%0t: table row disagrees: expected %0d %0d %0d, predicted %0d %0d %0d",
                             $realtime, typed.speed, typed.rate, typed.at_goal,
                             exp_cmd.speed, exp_cmd.rate, exp_cmd.at_goal);
                    errors++;
                end
                if (m_axis_tdata[14:0] !== exp_cmd.speed)
                begin
                    $display("%0t: linear_speed expected %0d actual %0d", $realtime,
                             exp_cmd.speed, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tdata[30:15] !== exp_cmd.rate)
                begin
                    $display("%0t: angular_rate expected %0d actual %0d", $realtime,
                             exp_cmd.rate, $signed(m_axis_tdata[30:15]));
                    errors++;
                end
                if (m_axis_tdata[31] !== 1'b0)
                begin
                    $display("%0t: pad bit expected 0 actual %b", $realtime, m_axis_tdata[31]);
                    errors++;
                end
                if (m_axis_tuser !== exp_cmd.at_goal)
                begin
                    $display("%0t: at_goal expected %b actual %b", $realtime,
                             exp_cmd.at_goal, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #3ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        pose_row_t directed[$];
        lin_gain = 4096;
        ang_gain = 7373;
        dist_tol = 102;
        head_tol = 41;
        dist_lim = 2048;
        directed = '{
            row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1),           // zero error vector
            row(0, 0, 0, 0, 0, 0, 0, 4096, 0, 1, 0, 7373, 1),     // turn to leader heading
            row(0, 0, 0, 0, 0, 0, 0, 40, 0, 1, 0, 0, 1),          // inside heading dead band
            row(0, 0, 0, 0, 0, 0, 0, -41, 0),                     // edge of dead band
            row(0, 0, 0, 0, -12868, 0, 0, 12868, 0, 1, 0, 32767, 1),
            row(0, 0, 0, 0, 12868, 0, 0, -12868, 0, 1, 0, -32768, 1),
            row(32767, 0, -32768, 0, 12868, 0, 0, 0, 0),
            row(-32768, 0, 32767, 0, 0, 0, 0, 0, 0),              // bearing pi on y = 0
            row(0, -32768, 0, 32767, -12868, 0, 0, 0, 0),
            row(-1000, -500, 0, 0, 0, 0, 0, 0, 0),
            row(1024, 0, 0, 0, 0, 0, 0, 12868, 1),
            row(32767, 32767, -32768, -32768, 0, 32767, 32767, -12868, 1),
            row(-1, -1, -1, -1, -1, -1, -1, -1, 1),
            row(300, 200, 100, 100, 6434, 50, -50, -6434, 1),
            row(2000, -3000, -1000, 1000, -3000, 0, 0, 3000, 0)
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_pose(directed[k].pose, directed[k].known, directed[k].cmd);
        run_random(150);
        drain();

        // maximum gains, no distance tolerance, widest heading tolerance and clamp; sender mostly idle
        write_reg(REG_LINEAR_GAIN, 65535);
        write_reg(REG_ANGULAR_GAIN, 65535);
        write_reg(REG_DIST_TOL, 0);
        write_reg(REG_HEADING_TOL, 32767);
        write_reg(REG_DIST_LIMIT, 32767);
        idle_pct = 76;
        run_random(80);
        drain();                                      // hold off until all commands are back
        run_random(80);
        drain();

        // clamp below tolerance: always at goal; receiver stalls
        write_reg(REG_LINEAR_GAIN, 0);
        write_reg(REG_ANGULAR_GAIN, 1);
        write_reg(REG_DIST_TOL, 32767);
        write_reg(REG_HEADING_TOL, 0);
        write_reg(REG_DIST_LIMIT, 0);
        idle_pct = 0;
        stall_pct = 76;
        run_random(160);
        drain();

        write_reg(REG_LINEAR_GAIN, $urandom_range(65535));
        write_reg(REG_ANGULAR_GAIN, $urandom_range(65535));
        write_reg(REG_DIST_TOL, $urandom_range(400));
        write_reg(REG_HEADING_TOL, $urandom_range(2000));
        write_reg(REG_DIST_LIMIT, $urandom_range(32767, 300));
        idle_pct = 23;
        stall_pct = 23;
        run_random(160);
        drain();

        if (errors == 0 && pending_cmds.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
